// ===== design/glyph_text_console_renderer_defines.svh =====
// Assertion macros for the glyph text console renderer.
// Included by the top level; depends on nothing else.
`ifndef GLYPH_TEXT_CONSOLE_RENDERER_DEFINES_SVH
`define GLYPH_TEXT_CONSOLE_RENDERER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GTCR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GTCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/gtcr_pkg.sv =====
// Shared types and constants of the glyph text console renderer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package gtcr_pkg;

  localparam int CHAR_COUNT_DEF     = 256;
  localparam int MAX_GLYPH_ROWS_DEF = 8;
  localparam int COORD_BITS_DEF     = 12;

  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int OUT_COORD_W = 12;

  localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd0;
  localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd1;
  localparam logic [2:0] REG_SCREEN_WIDTH = 3'd2;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd3;
  localparam logic [2:0] REG_FG_COLOR     = 3'd4;
  localparam logic [2:0] REG_BG_COLOR     = 3'd5;
  localparam logic [2:0] REG_OPAQUE_MODE  = 3'd6;
  localparam logic [2:0] REG_FONT_PRESENT = 3'd7;

  localparam logic KIND_FONT_WRITE = 1'b0;
  localparam logic KIND_CHAR       = 1'b1;

  localparam logic [3:0] GLYPH_MAX_W = 4'd8;

  typedef struct packed {
    logic [3:0]  glyph_width;
    logic [3:0]  glyph_height;
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    logic [31:0] fg_color;
    logic [31:0] bg_color;
    logic        opaque_mode;
    logic        font_present;
  } gtcr_cfg_t;

  localparam gtcr_cfg_t CFG_RESET = '{
    glyph_width:   4'd8,
    glyph_height:  4'd8,
    screen_width:  12'd640,
    screen_height: 12'd480,
    fg_color:      32'hFFFF_FFFF,
    bg_color:      32'h0000_0000,
    opaque_mode:   1'b1,
    font_present:  1'b0
  };

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } gtcr_alu_op_t;

endpackage

// ===== design/gtcr_cfg.sv =====
// APB configuration registers of the glyph text console renderer.
// Depends on gtcr_pkg for the register map and the configuration struct.
`timescale 1ns / 1ps

module gtcr_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gtcr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [gtcr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [gtcr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output gtcr_pkg::gtcr_cfg_t               cfg
);
  import gtcr_pkg::*;

  gtcr_cfg_t  cfg_r;
  gtcr_cfg_t  cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_GLYPH_WIDTH:   cfg_nxt.glyph_width   = pwdata[3:0];
        REG_GLYPH_HEIGHT:  cfg_nxt.glyph_height  = pwdata[3:0];
        REG_SCREEN_WIDTH:  cfg_nxt.screen_width  = pwdata[11:0];
        REG_SCREEN_HEIGHT: cfg_nxt.screen_height = pwdata[11:0];
        REG_FG_COLOR:      cfg_nxt.fg_color      = pwdata;
        REG_BG_COLOR:      cfg_nxt.bg_color      = pwdata;
        REG_OPAQUE_MODE:   cfg_nxt.opaque_mode   = pwdata[0];
        REG_FONT_PRESENT:  cfg_nxt.font_present  = pwdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GLYPH_WIDTH:   prdata = CFG_DATA_W'(cfg_r.glyph_width);
      REG_GLYPH_HEIGHT:  prdata = CFG_DATA_W'(cfg_r.glyph_height);
      REG_SCREEN_WIDTH:  prdata = CFG_DATA_W'(cfg_r.screen_width);
      REG_SCREEN_HEIGHT: prdata = CFG_DATA_W'(cfg_r.screen_height);
      REG_FG_COLOR:      prdata = cfg_r.fg_color;
      REG_BG_COLOR:      prdata = cfg_r.bg_color;
      REG_OPAQUE_MODE:   prdata = CFG_DATA_W'(cfg_r.opaque_mode);
      REG_FONT_PRESENT:  prdata = CFG_DATA_W'(cfg_r.font_present);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== design/gtcr_font_mem.sv =====
// Font store: one write port and one registered read port.
// Depends on gtcr_pkg for the default depth.
`timescale 1ns / 1ps

module gtcr_font_mem #(
  parameter int DEPTH  = gtcr_pkg::CHAR_COUNT_DEF * gtcr_pkg::MAX_GLYPH_ROWS_DEF,
  parameter int ADDR_W = $clog2(gtcr_pkg::CHAR_COUNT_DEF * gtcr_pkg::MAX_GLYPH_ROWS_DEF)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);
  import gtcr_pkg::*;

  logic [7:0] font_ram [DEPTH];
  logic [7:0] rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      font_ram[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= font_ram[rd_addr];
    end
  end

endmodule

// ===== design/gtcr_alu.sv =====
// Shared coordinate adder, subtractor and limit comparator.
// Depends on gtcr_pkg for the operation codes.
`timescale 1ns / 1ps

module gtcr_alu #(
  parameter int COORD_BITS = gtcr_pkg::COORD_BITS_DEF
) (
  input  gtcr_pkg::gtcr_alu_op_t op,
  input  logic [COORD_BITS-1:0]  a,
  input  logic [3:0]             b,
  input  logic [11:0]            limit,
  output logic [COORD_BITS:0]    result,
  output logic                   flag
);
  import gtcr_pkg::*;

  localparam int XW = (COORD_BITS + 1 > 12) ? COORD_BITS + 1 : 12;

  logic [COORD_BITS:0] a_x;
  logic [COORD_BITS:0] b_x;
  logic [COORD_BITS:0] sum;
  logic [COORD_BITS:0] diff;
  logic [XW-1:0]       sum_x;
  logic [XW-1:0]       lim_x;

  assign a_x   = {1'b0, a};
  assign b_x   = (COORD_BITS + 1)'(b);
  assign sum   = a_x + b_x;
  assign diff  = a_x - b_x;
  assign sum_x = XW'(sum);
  assign lim_x = XW'(limit);

  // For a subtraction the flag is the borrow.
  always_comb begin
    case (op)
      ALU_ADD: begin
        result = sum;
        flag   = (sum_x >= lim_x);
      end
      ALU_SUB: begin
        result = diff;
        flag   = diff[COORD_BITS];
      end
      default: begin
        result = sum;
        flag   = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/gtcr_seq.sv =====
// Sequencer of the glyph text console renderer: cursor, font access and pixel output.
// Depends on gtcr_pkg, and drives gtcr_font_mem and gtcr_alu from the top level.
`timescale 1ns / 1ps

module gtcr_seq #(
  parameter int CHAR_COUNT     = gtcr_pkg::CHAR_COUNT_DEF,
  parameter int MAX_GLYPH_ROWS = gtcr_pkg::MAX_GLYPH_ROWS_DEF,
  parameter int COORD_BITS     = gtcr_pkg::COORD_BITS_DEF,
  parameter int ADDR_W         = $clog2(gtcr_pkg::CHAR_COUNT_DEF *
                                        gtcr_pkg::MAX_GLYPH_ROWS_DEF)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gtcr_pkg::gtcr_cfg_t    cfg,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_kind,
  input  logic [7:0]             in_char_code,
  input  logic [2:0]             in_glyph_row,
  input  logic [7:0]             in_row_bits,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [11:0]            out_pixel_x,
  output logic [11:0]            out_pixel_y,
  output logic [31:0]            out_pixel_color,
  output logic                   out_write_enable,
  output logic                   out_scroll_before,
  output logic                   out_last_pixel,
  output logic                   mem_wr_en,
  output logic [ADDR_W-1:0]      mem_wr_addr,
  output logic [7:0]             mem_wr_data,
  output logic                   mem_rd_en,
  output logic [ADDR_W-1:0]      mem_rd_addr,
  input  logic [7:0]             mem_rd_data,
  output gtcr_pkg::gtcr_alu_op_t alu_op,
  output logic [COORD_BITS-1:0]  alu_a,
  output logic [3:0]             alu_b,
  output logic [11:0]            alu_limit,
  input  logic [COORD_BITS:0]    alu_result,
  input  logic                   alu_flag
);
  import gtcr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRAP,
    S_NEWLINE,
    S_SCROLL,
    S_UP,
    S_FETCH,
    S_LOAD,
    S_PIX,
    S_ADV
  } state_t;

  state_t                state_r, state_nxt;
  logic [COORD_BITS-1:0] cx_r, cx_nxt;
  logic [COORD_BITS-1:0] cy_r, cy_nxt;
  logic [COORD_BITS-1:0] px_r, px_nxt;
  logic [COORD_BITS-1:0] py_r, py_nxt;
  logic [7:0]            code_r, code_nxt;
  logic                  blank_r, blank_nxt;
  logic                  scroll_r, scroll_nxt;
  logic                  first_r, first_nxt;
  logic [2:0]            row_r, row_nxt;
  logic [2:0]            col_r, col_nxt;
  logic [7:0]            shreg_r, shreg_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [11:0]           pix_x_r, pix_x_nxt;
  logic [11:0]           pix_y_r, pix_y_nxt;
  logic [31:0]           color_r, color_nxt;
  logic                  we_r, we_nxt;
  logic                  scr_r, scr_nxt;
  logic                  last_r, last_nxt;

  logic [3:0] gw;
  logic [3:0] gh;
  logic [2:0] gw_m1;
  logic [2:0] gh_m1;
  logic       in_acc;
  logic       emit;
  logic       row_end;
  logic       last_row;
  logic [3:0] rd_row;
  logic       rd_row_ok;
  logic [7:0] load_bits;
  logic       wr_in_range;

  function automatic logic [ADDR_W-1:0] font_addr(input logic [7:0] code,
                                                  input logic [2:0] row);
    logic [11:0] full;
    full = 12'(code) * 12'(MAX_GLYPH_ROWS) + 12'(row);
    return full[ADDR_W-1:0];
  endfunction

  function automatic logic [7:0] align_row(input logic [7:0] bits, input logic [3:0] w);
    logic [3:0] sh;
    sh = GLYPH_MAX_W - w;
    return bits << sh[2:0];
  endfunction

  function automatic logic [11:0] to_out(input logic [COORD_BITS-1:0] v);
    logic [COORD_BITS+11:0] t;
    t = (COORD_BITS + 12)'(v);
    return t[11:0];
  endfunction

  always_comb begin
    if (cfg.glyph_width == 4'd0) begin
      gw = 4'd1;
    end else if (cfg.glyph_width > GLYPH_MAX_W) begin
      gw = GLYPH_MAX_W;
    end else begin
      gw = cfg.glyph_width;
    end
    if (cfg.glyph_height == 4'd0) begin
      gh = 4'd1;
    end else if (cfg.glyph_height > 4'(MAX_GLYPH_ROWS)) begin
      gh = 4'(MAX_GLYPH_ROWS);
    end else begin
      gh = cfg.glyph_height;
    end
  end

  assign gw_m1 = 3'(gw - 4'd1);
  assign gh_m1 = 3'(gh - 4'd1);

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign emit     = (state_r == S_PIX) && (!out_valid_r || !out_stall);
  assign row_end  = (col_r == gw_m1);
  assign last_row = (row_r == gh_m1);

  assign wr_in_range = (9'(in_char_code) < 9'(CHAR_COUNT)) &&
                       (4'(in_glyph_row) < 4'(MAX_GLYPH_ROWS));
  assign mem_wr_en   = in_acc && (in_kind == KIND_FONT_WRITE) && wr_in_range;
  assign mem_wr_addr = font_addr(in_char_code, in_glyph_row);
  assign mem_wr_data = in_row_bits;

  // The next row is read while the current one is shifted out.
  always_comb begin
    case (state_r)
      S_FETCH: rd_row = 4'd0;
      S_LOAD:  rd_row = 4'(row_r) + 4'd1;
      default: rd_row = 4'(row_r) + 4'd2;
    endcase
  end

  assign rd_row_ok   = (rd_row < gh);
  assign mem_rd_addr = font_addr(code_r, rd_row[2:0]);
  assign mem_rd_en   = (state_r == S_FETCH) ||
                       ((state_r == S_LOAD) && rd_row_ok) ||
                       (emit && row_end && !last_row && rd_row_ok);
  assign load_bits   = blank_r ? 8'h00 : align_row(mem_rd_data, gw);

  always_comb begin
    case (state_r)
      S_NEWLINE, S_SCROLL: begin
        alu_op    = ALU_ADD;
        alu_a     = cy_r;
        alu_b     = gh;
        alu_limit = cfg.screen_height;
      end
      S_UP: begin
        alu_op    = ALU_SUB;
        alu_a     = cy_r;
        alu_b     = gh;
        alu_limit = cfg.screen_height;
      end
      default: begin
        alu_op    = ALU_ADD;
        alu_a     = cx_r;
        alu_b     = gw;
        alu_limit = cfg.screen_width;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    code_nxt      = code_r;
    blank_nxt     = blank_r;
    scroll_nxt    = scroll_r;
    first_nxt     = first_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    shreg_nxt     = shreg_r;
    out_valid_nxt = out_valid_r && out_stall;
    pix_x_nxt     = pix_x_r;
    pix_y_nxt     = pix_y_r;
    color_nxt     = color_r;
    we_nxt        = we_r;
    scr_nxt       = scr_r;
    last_nxt      = last_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_kind == KIND_CHAR) && cfg.font_present) begin
          code_nxt   = in_char_code;
          blank_nxt  = !(9'(in_char_code) < 9'(CHAR_COUNT));
          scroll_nxt = 1'b0;
          first_nxt  = 1'b1;
          state_nxt  = S_WRAP;
        end
      end
      S_WRAP: begin
        if (alu_flag) begin
          cx_nxt    = '0;
          state_nxt = S_NEWLINE;
        end else begin
          state_nxt = S_SCROLL;
        end
      end
      S_NEWLINE: begin
        cy_nxt    = alu_result[COORD_BITS-1:0];
        state_nxt = S_SCROLL;
      end
      S_SCROLL: begin
        if (alu_flag) begin
          scroll_nxt = 1'b1;
          state_nxt  = S_UP;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_UP: begin
        cy_nxt    = alu_flag ? '0 : alu_result[COORD_BITS-1:0];
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        row_nxt   = 3'd0;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        shreg_nxt = load_bits;
        col_nxt   = 3'd0;
        px_nxt    = cx_r;
        py_nxt    = cy_r;
        state_nxt = S_PIX;
      end
      S_PIX: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          pix_x_nxt     = to_out(px_r);
          pix_y_nxt     = to_out(py_r);
          we_nxt        = shreg_r[7] || cfg.opaque_mode;
          if (shreg_r[7]) begin
            color_nxt = cfg.fg_color;
          end else if (cfg.opaque_mode) begin
            color_nxt = cfg.bg_color;
          end else begin
            color_nxt = '0;
          end
          scr_nxt   = first_r && scroll_r;
          last_nxt  = row_end && last_row;
          first_nxt = 1'b0;
          if (row_end) begin
            if (last_row) begin
              state_nxt = S_ADV;
            end else begin
              row_nxt   = row_r + 3'd1;
              col_nxt   = 3'd0;
              shreg_nxt = load_bits;
              px_nxt    = cx_r;
              py_nxt    = py_r + COORD_BITS'(1);
            end
          end else begin
            col_nxt   = col_r + 3'd1;
            shreg_nxt = {shreg_r[6:0], 1'b0};
            px_nxt    = px_r + COORD_BITS'(1);
          end
        end
      end
      S_ADV: begin
        cx_nxt    = alu_result[COORD_BITS-1:0];
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cx_r        <= '0;
      cy_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    code_r   <= code_nxt;
    blank_r  <= blank_nxt;
    scroll_r <= scroll_nxt;
    first_r  <= first_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    shreg_r  <= shreg_nxt;
    pix_x_r  <= pix_x_nxt;
    pix_y_r  <= pix_y_nxt;
    color_r  <= color_nxt;
    we_r     <= we_nxt;
    scr_r    <= scr_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_x       = pix_x_r;
  assign out_pixel_y       = pix_y_r;
  assign out_pixel_color   = color_r;
  assign out_write_enable  = we_r;
  assign out_scroll_before = scr_r;
  assign out_last_pixel    = last_r;

endmodule

// ===== design/glyph_text_console_renderer.sv =====
// Glyph text console renderer. A font-write beat leaves the block idle. A character beat
// yields glyph_width * glyph_height pixels with cursor work around them (wrap test, new
// line, scroll test, scroll move, font fetch and row load before the pixels, cursor
// advance after them; the tests, new line, scroll move and advance share one adder and
// comparator; new line and scroll move only when needed), then returns to idle, where the
// next beat is taken; the pixel output register hands out at most one pixel per cycle,
// and output stall holds it. A character beat while font_present is clear, and a
// font-write beat, produce no pixels. The consumer performs the scroll itself.
// Depends on gtcr_pkg, gtcr_cfg, gtcr_font_mem, gtcr_alu, gtcr_seq and the defines header.
`timescale 1ns / 1ps

`include "glyph_text_console_renderer_defines.svh"

module glyph_text_console_renderer #(
  parameter int CHAR_COUNT     = gtcr_pkg::CHAR_COUNT_DEF,
  parameter int MAX_GLYPH_ROWS = gtcr_pkg::MAX_GLYPH_ROWS_DEF,
  parameter int COORD_BITS     = gtcr_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [7:0]                      in_char_code,
  input  logic [2:0]                      in_glyph_row,
  input  logic [7:0]                      in_row_bits,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [11:0]                     out_pixel_x,
  output logic [11:0]                     out_pixel_y,
  output logic [31:0]                     out_pixel_color,
  output logic                            out_write_enable,
  output logic                            out_scroll_before,
  output logic                            out_last_pixel,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gtcr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [gtcr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [gtcr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import gtcr_pkg::*;

  localparam int FONT_DEPTH = CHAR_COUNT * MAX_GLYPH_ROWS;
  localparam int FONT_AW    = $clog2(FONT_DEPTH);

  gtcr_cfg_t             cfg_s;
  logic                  mem_wr_en;
  logic [FONT_AW-1:0]    mem_wr_addr;
  logic [7:0]            mem_wr_data;
  logic                  mem_rd_en;
  logic [FONT_AW-1:0]    mem_rd_addr;
  logic [7:0]            mem_rd_data;
  gtcr_alu_op_t          alu_op;
  logic [COORD_BITS-1:0] alu_a;
  logic [3:0]            alu_b;
  logic [11:0]           alu_limit;
  logic [COORD_BITS:0]   alu_result;
  logic                  alu_flag;

  gtcr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg_s)
  );

  gtcr_font_mem #(
    .DEPTH  (FONT_DEPTH),
    .ADDR_W (FONT_AW)
  ) u_font_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  gtcr_alu #(
    .COORD_BITS (COORD_BITS)
  ) u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .limit  (alu_limit),
    .result (alu_result),
    .flag   (alu_flag)
  );

  gtcr_seq #(
    .CHAR_COUNT     (CHAR_COUNT),
    .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS),
    .COORD_BITS     (COORD_BITS),
    .ADDR_W         (FONT_AW)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_s),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_char_code      (in_char_code),
    .in_glyph_row      (in_glyph_row),
    .in_row_bits       (in_row_bits),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_color   (out_pixel_color),
    .out_write_enable  (out_write_enable),
    .out_scroll_before (out_scroll_before),
    .out_last_pixel    (out_last_pixel),
    .mem_wr_en         (mem_wr_en),
    .mem_wr_addr       (mem_wr_addr),
    .mem_wr_data       (mem_wr_data),
    .mem_rd_en         (mem_rd_en),
    .mem_rd_addr       (mem_rd_addr),
    .mem_rd_data       (mem_rd_data),
    .alu_op            (alu_op),
    .alu_a             (alu_a),
    .alu_b             (alu_b),
    .alu_limit         (alu_limit),
    .alu_result        (alu_result),
    .alu_flag          (alu_flag)
  );

  `GTCR_ASSERT_SAME(a_busy_mid_char, clk, rst_n, out_valid && !out_last_pixel, in_stall, "pixel pending without a character in progress")
  `GTCR_ASSERT_NEXT(a_no_work_idle, clk, rst_n, in_valid && !in_stall && ((in_kind == KIND_FONT_WRITE) || !cfg_s.font_present), !in_stall, "beat without pixels left the block busy")
  `GTCR_ASSERT_NEXT(a_char_starts, clk, rst_n, in_valid && !in_stall && (in_kind == KIND_CHAR) && cfg_s.font_present, in_stall, "character beat did not start rendering")
  `GTCR_ASSERT_SAME(a_skip_no_color, clk, rst_n, out_valid && !out_write_enable, out_pixel_color == 32'h0000_0000, "skipped pixel carries a color")

endmodule
